/* sv/srd_pkg.sv */
package srd_pkg;

    // fixed field widths
    localparam int DIGIT_BITS = 4;
    localparam int CHAR_BITS  = 8;
    localparam int RADIX_BITS = 5;
    localparam int WORD_BITS  = 64;

    // register indexes on the configuration port
    localparam logic [1:0] REG_RADIX_LENGTH = 2'd0;
    localparam logic [1:0] REG_CHARS_LOW    = 2'd1;
    localparam logic [1:0] REG_CHARS_HIGH   = 2'd2;

    // character codes that may not be digits
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'd32;
    localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_BITS-1:0] CHAR_DEL   = 8'd127;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
    } div_ctl_t;

    // divider status back to the sequencer
    typedef struct packed {
        logic                  done;
        logic                  quot_nonzero;
        logic [DIGIT_BITS-1:0] remainder;
    } div_stat_t;

endpackage

/* sv/srd_serial_div.sv */
module srd_serial_div #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  srd_pkg::div_ctl_t                     ctl,
    input  logic [VALUE_BITS-1:0]                 dividend,
    input  logic [srd_pkg::RADIX_BITS-1:0]        radix,
    output srd_pkg::div_stat_t                    stat,
    output logic [VALUE_BITS-1:0]                 quotient
);

    localparam int CNT_W = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0]              q_reg, q_next;
    logic [srd_pkg::DIGIT_BITS-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic                               qnz_reg, qnz_next;
    logic [srd_pkg::RADIX_BITS-1:0]     trial;
    logic [srd_pkg::RADIX_BITS-1:0]     diff;
    logic                               fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign fits  = (trial >= radix);
    assign diff  = trial - radix;

    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qnz_next  = qnz_reg;
        if (ctl.start) begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(VALUE_BITS - 1);
            busy_next = 1'b1;
            qnz_next  = 1'b0;
        end else if (busy_reg) begin
            q_next   = {q_reg[VALUE_BITS-2:0], fits};
            rem_next = fits ? diff[srd_pkg::DIGIT_BITS-1:0]
                            : trial[srd_pkg::DIGIT_BITS-1:0];
            qnz_next = qnz_reg | fits;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        qnz_reg <= qnz_next;
    end

    assign stat.done         = done_reg;
    assign stat.quot_nonzero = qnz_reg;
    assign stat.remainder    = rem_reg;
    assign quotient          = q_reg;

endmodule

/* sv/signed_integer_to_radix_digits_core.sv */
// steps: alphabet check over radix_length characters, then one bit-serial division per digit,
//   then the characters (sign, then digits), each held in the output register while it stalls
// one value at a time: the next request is taken once the last character is in the output
//   register; the per-digit divider loop sets the rate
// invalid alphabet: the request is taken, the check stops at the first fault, nothing is emitted
// synchronous active-low reset clears control state and all configuration registers
module signed_integer_to_radix_digits_core #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_char
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DB    = srd_pkg::DIGIT_BITS;
    localparam int CB    = srd_pkg::CHAR_BITS;
    localparam int RB    = srd_pkg::RADIX_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // character k of the alphabet
    function automatic logic [CB-1:0] alpha_char(input logic [63:0] lo,
                                                 input logic [63:0] hi,
                                                 input logic [DB-1:0] k);
        logic [63:0] word;
        word = k[DB-1] ? hi : lo;
        return word[k[DB-2:0]*CB +: CB];
    endfunction

    logic [RB-1:0]          radix_len_reg;
    logic [63:0]            chars_lo_reg;
    logic [63:0]            chars_hi_reg;
    logic [2:0]             state_reg, state_next;
    logic [VALUE_BITS-1:0]  mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [DB-1:0]          chk_idx_reg, chk_idx_next;
    logic [CNT_W-1:0]       dig_cnt_reg, dig_cnt_next;
    logic [DB-1:0]          stack_reg [VALUE_BITS];
    logic                   push, pop;
    logic                   m_valid_reg, m_valid_next;
    logic [CB-1:0]          m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic [VALUE_BITS-1:0]  raw;
    logic                   out_free;
    logic                   len_bad;
    logic [CB-1:0]          cur_char;
    logic                   char_bad;
    logic                   dup;
    logic                   chk_last;
    logic [CNT_W-1:0]       cnt_inc;

    srd_pkg::div_ctl_t      div_ctl;
    srd_pkg::div_stat_t     div_stat;
    logic [VALUE_BITS-1:0]  div_dividend;
    logic [VALUE_BITS-1:0]  div_quot;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_len_reg <= '0;
            chars_lo_reg  <= '0;
            chars_hi_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                srd_pkg::REG_RADIX_LENGTH: radix_len_reg <= cfg_data[RB-1:0];
                srd_pkg::REG_CHARS_LOW:    chars_lo_reg  <= cfg_data;
                srd_pkg::REG_CHARS_HIGH:   chars_hi_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // alphabet check for the character under the index
    assign raw      = s_number[VALUE_BITS-1:0];
    assign len_bad  = (radix_len_reg < RB'(2)) || (radix_len_reg > RB'(MAX_RADIX));
    assign cur_char = alpha_char(chars_lo_reg, chars_hi_reg, chk_idx_reg);
    assign char_bad = (cur_char <= srd_pkg::CHAR_SPACE) || (cur_char == srd_pkg::CHAR_PLUS)
                   || (cur_char == srd_pkg::CHAR_MINUS) || (cur_char == srd_pkg::CHAR_DEL);
    assign chk_last = ({1'b0, chk_idx_reg} + RB'(1)) == radix_len_reg;

    always_comb begin
        dup = 1'b0;
        for (int j = 0; j < MAX_RADIX; j++) begin
            if ((RB'(j) > {1'b0, chk_idx_reg}) && (RB'(j) < radix_len_reg)
                && (alpha_char(chars_lo_reg, chars_hi_reg, DB'(j)) == cur_char)) begin
                dup = 1'b1;
            end
        end
    end

    // bit-serial divider, restarted on its own quotient for each digit
    assign div_dividend = (state_reg == ST_DIV) ? div_quot : mag_reg;

    srd_serial_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .radix    (radix_len_reg),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign cnt_inc  = dig_cnt_reg + 1'b1;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        chk_idx_next  = chk_idx_reg;
        dig_cnt_next  = dig_cnt_reg;
        push          = 1'b0;
        pop           = 1'b0;
        div_ctl.start = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_char_next   = m_char_reg;
        m_last_next   = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
                    chk_idx_next = '0;
                    dig_cnt_next = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (len_bad || char_bad || dup) begin
                    state_next = ST_IDLE;
                end else if (chk_last) begin
                    div_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    chk_idx_next = chk_idx_reg + 1'b1;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    push         = 1'b1;
                    dig_cnt_next = cnt_inc;
                    if (div_stat.quot_nonzero && (cnt_inc < CNT_W'(VALUE_BITS))) begin
                        div_ctl.start = 1'b1;
                    end else begin
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = srd_pkg::CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = alpha_char(chars_lo_reg, chars_hi_reg, stack_reg[0]);
                    m_last_next  = (dig_cnt_reg == CNT_W'(1));
                    pop          = 1'b1;
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // digit stack: newest digit on top, so digits leave most significant first
    always_ff @(posedge aclk) begin
        if (push) begin
            stack_reg[0] <= div_stat.remainder;
            for (int k = 1; k < VALUE_BITS; k++) begin
                stack_reg[k] <= stack_reg[k-1];
            end
        end else if (pop) begin
            for (int k = 0; k < VALUE_BITS - 1; k++) begin
                stack_reg[k] <= stack_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            dig_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            dig_cnt_reg <= dig_cnt_next;
        end
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        chk_idx_reg <= chk_idx_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule

/* dv/signed_integer_to_radix_digits_core_test.sv */
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_core_test;

    localparam int RADIX_MAX    = 16;
    localparam int NUMBER_BITS  = 32;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 285;
    localparam int QUIET_ITEMS  = 40;

    // spare register index, not decoded by the block
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [srd_pkg::CHAR_BITS-1:0] code;
        logic                          last;
    } glyph_t;

    typedef enum logic {ROW_WRITE, ROW_NUMBER} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  index;
        logic [63:0] data;
        logic [31:0] number;
        bit          typed;
        string       text;
    } plan_row_t;

    typedef enum logic [1:0] {FLAW_SHORT, FLAW_LONG, FLAW_BAD_GLYPH, FLAW_DUPLICATE} flaw_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = srd_pkg::REG_RADIX_LENGTH;
    logic [63:0] cfg_data    = '0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_number    = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_last_char;

    // shadow of the alphabet registers
    logic [srd_pkg::RADIX_BITS-1:0] radix_len  = '0;
    logic [srd_pkg::WORD_BITS-1:0]  chars_low  = '0;
    logic [srd_pkg::WORD_BITS-1:0]  chars_high = '0;

    glyph_t      pending_chars [$];
    plan_row_t   plan [$];
    int          fail_count = 0;
    bit          quiet_tail = 1'b0;
    int unsigned stall_left = 0;
    int unsigned calm_left  = 0;

    signed_integer_to_radix_digits_core #(
        .MAX_RADIX  (RADIX_MAX),
        .VALUE_BITS (NUMBER_BITS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_number    (s_number),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [srd_pkg::CHAR_BITS-1:0] alphabet_glyph(
        input logic [srd_pkg::DIGIT_BITS-1:0] k);
        return k[3] ? chars_high[k[2:0]*8 +: 8] : chars_low[k[2:0]*8 +: 8];
    endfunction

    // length in range, no blank, sign or delete glyph, no repeats
    function automatic bit alphabet_usable();
        logic [srd_pkg::CHAR_BITS-1:0] c;
        if (radix_len < 2 || radix_len > RADIX_MAX) return 1'b0;
        for (int i = 0; i < radix_len; i++) begin
            c = alphabet_glyph(srd_pkg::DIGIT_BITS'(i));
            if (c <= srd_pkg::CHAR_SPACE || c == srd_pkg::CHAR_PLUS
                || c == srd_pkg::CHAR_MINUS || c == srd_pkg::CHAR_DEL)
                return 1'b0;
            for (int j = i + 1; j < radix_len; j++)
                if (alphabet_glyph(srd_pkg::DIGIT_BITS'(j)) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    // expected characters of one conversion, most significant first
    function automatic void spell_number(input logic [31:0] value);
        logic [srd_pkg::DIGIT_BITS-1:0] digits [NUMBER_BITS];
        logic [31:0]                    mag;
        logic [31:0]                    base;
        int                             count;
        if (!alphabet_usable()) return;
        base  = 32'(radix_len);
        mag   = value[31] ? -value : value;
        count = 0;
        do begin
            digits[count] = srd_pkg::DIGIT_BITS'(mag % base);
            mag = mag / base;
            count++;
        end while (mag != 0);
        if (value[31]) pending_chars.push_back('{code: srd_pkg::CHAR_MINUS, last: 1'b0});
        for (int i = count - 1; i >= 0; i--)
            pending_chars.push_back('{code: alphabet_glyph(digits[i]), last: (i == 0)});
    endfunction

    function automatic plan_row_t write_row(input logic [1:0] index, input logic [63:0] data);
        plan_row_t row;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data;
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic plan_row_t number_row(input logic [31:0] number);
        plan_row_t row;
        row.kind   = ROW_NUMBER;
        row.number = number;
        row.typed  = 1'b0;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic [31:0] number, input string text);
        plan_row_t row;
        row.kind   = ROW_NUMBER;
        row.number = number;
        row.typed  = 1'b1;
        row.text   = text;
        return row;
    endfunction

    // mix of wide, short, extreme and near radix-power values
    function automatic logic [31:0] pick_number();
        longint unsigned span;
        longint unsigned base;
        logic [31:0]     value;
        base = (radix_len >= 2 && radix_len <= RADIX_MAX) ? radix_len : 10;
        case ($urandom_range(0, 7))
            0, 1, 2: value = $urandom;
            3: value = $urandom_range(0, 300);
            4: begin
                case ($urandom_range(0, 3))
                    0: value = 32'h8000_0000;
                    1: value = 32'h7FFF_FFFF;
                    2: value = 32'h0000_0000;
                    default: value = 32'h8000_0001;
                endcase
            end
            5: begin
                span = 1;
                repeat ($urandom_range(1, 31))
                    if (span * base < 64'h8000_0000) span = span * base;
                value = 32'(span) - 32'($urandom_range(0, 1));
            end
            default: value = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) == 1) value = -value;
        return value;
    endfunction

    // hold the number request until taken, with an optional gap first
    task automatic send_number(input logic [31:0] value);
        if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            s_valid  <= 1'b0;
            s_number <= $urandom;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_number <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // block must be idle before a register changes
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            srd_pkg::REG_RADIX_LENGTH: radix_len  = data[srd_pkg::RADIX_BITS-1:0];
            srd_pkg::REG_CHARS_LOW:    chars_low  = data;
            srd_pkg::REG_CHARS_HIGH:   chars_high = data;
            default: ;
        endcase
    endtask

    // random distinct glyphs, optionally broken in one way
    task automatic load_random_alphabet(input bit make_bad);
        logic [srd_pkg::CHAR_BITS-1:0]  glyphs [RADIX_MAX];
        logic [srd_pkg::RADIX_BITS-1:0] len;
        logic [srd_pkg::CHAR_BITS-1:0]  c;
        logic [63:0]                    low_word;
        logic [63:0]                    high_word;
        bit                             fresh;
        int                             p;
        int                             q;
        flaw_t                          flaw;
        if ($urandom_range(0, 3) == 0)
            len = ($urandom_range(0, 1) == 0) ? srd_pkg::RADIX_BITS'(2)
                                              : srd_pkg::RADIX_BITS'(RADIX_MAX);
        else
            len = srd_pkg::RADIX_BITS'($urandom_range(2, RADIX_MAX));
        foreach (glyphs[k]) glyphs[k] = srd_pkg::CHAR_BITS'($urandom);
        for (int k = 0; k < len; k++) begin
            do begin
                c = srd_pkg::CHAR_BITS'($urandom_range(33, 255));
                fresh = (c != srd_pkg::CHAR_PLUS) && (c != srd_pkg::CHAR_MINUS)
                     && (c != srd_pkg::CHAR_DEL);
                for (int j = 0; j < k; j++)
                    if (glyphs[j] == c) fresh = 1'b0;
            end while (!fresh);
            glyphs[k] = c;
        end
        if (make_bad) begin
            flaw = flaw_t'($urandom_range(0, 3));
            case (flaw)
                FLAW_SHORT: len = srd_pkg::RADIX_BITS'($urandom_range(0, 1));
                FLAW_LONG: len = srd_pkg::RADIX_BITS'($urandom_range(RADIX_MAX + 1, 31));
                FLAW_BAD_GLYPH: begin
                    p = $urandom_range(0, len - 1);
                    case ($urandom_range(0, 3))
                        0: glyphs[p] = srd_pkg::CHAR_PLUS;
                        1: glyphs[p] = srd_pkg::CHAR_MINUS;
                        2: glyphs[p] = srd_pkg::CHAR_DEL;
                        default: glyphs[p] = srd_pkg::CHAR_BITS'($urandom_range(0, 32));
                    endcase
                end
                default: begin
                    p = $urandom_range(0, len - 2);
                    q = $urandom_range(p + 1, len - 1);
                    glyphs[q] = glyphs[p];
                end
            endcase
        end
        for (int k = 0; k < 8; k++) begin
            low_word[k*8 +: 8]  = glyphs[k];
            high_word[k*8 +: 8] = glyphs[k+8];
        end
        wait_idle();
        write_register(srd_pkg::REG_RADIX_LENGTH, {$urandom, 27'($urandom), len});
        write_register(srd_pkg::REG_CHARS_LOW, low_word);
        write_register(srd_pkg::REG_CHARS_HIGH, high_word);
        cfg_valid <= 1'b0;
    endtask

    // result side stalls in bursts, with calm stretches between
    always @(posedge aclk) begin
        if (quiet_tail) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (calm_left != 0) begin
            calm_left--;
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(50, 300);
            m_ready <= 1'b1;
        end
    end

    // compare each character request with the oldest expectation
    always @(posedge aclk) begin
        glyph_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character: out_char %h last_char %b", m_out_char, m_last_char);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_out_char !== want.code) begin
                    $error("out_char expected %h actual %h", want.code, m_out_char);
                    fail_count++;
                end
                if (m_last_char !== want.last) begin
                    $error("last_char expected %b actual %b", want.last, m_last_char);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        logic [31:0] value;
        int          spelled;
        int          burst;
        bit          make_bad;

        plan = {
            // nothing configured after reset
            typed_row(32'd5, ""),
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd10),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_3332_3130),
            // junk beyond the alphabet length is ignored
            write_row(srd_pkg::REG_CHARS_HIGH, 64'h2020_2B2D_7F00_3938),
            typed_row(32'h0000_0000, "0"),
            typed_row(32'h7FFF_FFFF, "2147483647"),
            typed_row(32'h8000_0000, "-2147483648"),
            typed_row(32'hFFFF_FFFF, "-1"),
            number_row(32'd1234567890),
            number_row(-32'sd987654),
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd16),
            write_row(srd_pkg::REG_CHARS_HIGH, 64'h6665_6463_6261_3938),
            typed_row(32'h8000_0000, "-80000000"),
            typed_row(32'h7FFF_FFFF, "7fffffff"),
            number_row(32'hDEAD_BEEF),
            // binary, longest output
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd2),
            number_row(32'h8000_0000),
            number_row(32'h7FFF_FFFF),
            typed_row(32'h0000_0001, "1"),
            // length out of range
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd1),
            typed_row(32'd7, ""),
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd17),
            typed_row(32'd7, ""),
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd31),
            typed_row(32'd7, ""),
            // forbidden glyphs inside the alphabet
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd10),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_2032_3130),
            typed_row(-32'sd5, ""),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_2B32_3130),
            typed_row(-32'sd5, ""),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_2D32_3130),
            typed_row(-32'sd5, ""),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_7F32_3130),
            typed_row(-32'sd5, ""),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_1F32_3130),
            typed_row(-32'sd5, ""),
            // repeated glyph across the two words
            write_row(srd_pkg::REG_CHARS_LOW, 64'h3736_3534_3332_3130),
            write_row(srd_pkg::REG_CHARS_HIGH, 64'h2020_2B2D_7F00_3930),
            typed_row(-32'sd5, ""),
            // upper half of the byte range as digits, plus one printable glyph
            write_row(srd_pkg::REG_RADIX_LENGTH, 64'd16),
            write_row(srd_pkg::REG_CHARS_LOW, 64'h8786_8584_8382_8180),
            write_row(srd_pkg::REG_CHARS_HIGH, 64'hFF8E_8D8C_8B8A_8921),
            number_row(32'h8000_0000),
            number_row(32'h0123_4567),
            // undecoded index leaves the alphabet alone
            write_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF),
            number_row(32'h7654_3210)
        };

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_WRITE) begin
                wait_idle();
                write_register(plan[r].index, plan[r].data);
                cfg_valid <= 1'b0;
            end else begin
                send_number(plan[r].number);
                if (plan[r].typed) begin
                    for (int i = 0; i < plan[r].text.len(); i++)
                        pending_chars.push_back('{code: plan[r].text[i],
                                                   last: (i == plan[r].text.len() - 1)});
                end else begin
                    spell_number(plan[r].number);
                end
            end
        end

        // random alphabets, mostly usable, each with a run of numbers
        spelled = 0;
        while (spelled < RANDOM_ITEMS) begin
            make_bad = ($urandom_range(0, 5) == 0);
            load_random_alphabet(make_bad);
            burst = make_bad ? $urandom_range(3, 6) : $urandom_range(20, 45);
            for (int n = 0; n < burst && spelled < RANDOM_ITEMS; n++) begin
                quiet_tail = (spelled >= RANDOM_ITEMS - QUIET_ITEMS);
                value = pick_number();
                send_number(value);
                if (alphabet_usable()) spelled++;
                spell_number(value);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
